>>> hdl/mhrb_pkg.sv
// shared types, codes and sizes for the holding register bank
`default_nettype none

package mhrb_pkg;

	localparam int BANK_WORDS = 64;
	localparam int IDX_W = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
	localparam int CNT_W = $clog2(BANK_WORDS + 2);

	localparam logic [1:0] CMD_READ      = 2'd0;
	localparam logic [1:0] CMD_WR_SINGLE = 2'd1;
	localparam logic [1:0] CMD_WR_HEADER = 2'd2;
	localparam logic [1:0] CMD_WR_DATA   = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_VALUE  = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR   = 2'd2;

	localparam logic [15:0] READ_MAX       = 16'd125;
	localparam logic [15:0] WR_MULTI_MAX   = 16'd120;
	localparam logic [7:0]  PDU_LEN_FIXED  = 8'd5;
	localparam logic [7:0]  PDU_LEN_MULTI  = 8'd6;
	localparam logic [15:0] FIRST_ADDR_RST = 16'd1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] start_address;
		logic [15:0] quantity;
		logic [7:0]  declared_bytes;
		logic [7:0]  pdu_length;
		logic [15:0] word_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic        second_present;
		logic        final_res;
	} rsp_t;

endpackage

`default_nettype wire

>>> hdl/modbus_holding_register_bank.sv
// holding register bank top level: request decode, bank memory and result register
//
// Request channel (in_valid / in_stall / in_data) carries read, write single,
// write multiple header and write multiple data word items. Result channel
// (out_valid / out_stall / out_data) returns one result per item, or for a
// good read one result per pair of registers, final_res on the last one.
// cfg_wr_en / cfg_wr_data set the one-based address of bank word 0.
// An item is taken into a register in S_IDLE and checked in S_EVAL. A read
// walks the bank memory two words per access, and each pair of read data is
// registered in S_RD_REQ before S_RD_DATA loads it as a result.
// Results go through an output register, so a new request is taken while a
// result still waits; a stalled receiver holds the check or read walk until
// that register frees, and no bank or pending state changes meanwhile.
// Reset clears the bank through per-word valid bits at once, clears any
// pending write multiple and sets the first address to 1; no clearing pass.
// Requests are accepted from the first cycle after reset.
`default_nettype none

module modbus_holding_register_bank (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire mhrb_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output mhrb_pkg::rsp_t      out_data,
	input  wire logic           cfg_wr_en,
	input  wire logic [15:0]    cfg_wr_data
);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_EVAL    = 4'b0010,
		S_RD_REQ  = 4'b0100,
		S_RD_DATA = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [15:0] first_addr_q;
	logic [16:0] win_end_q;

	mhrb_pkg::req_t item_q;

	logic                       pend_act_q;
	logic [mhrb_pkg::IDX_W-1:0] pend_idx_q;
	logic [mhrb_pkg::CNT_W-1:0] pend_rem_q;

	logic [mhrb_pkg::IDX_W-1:0] rd_ptr_q;
	logic [mhrb_pkg::CNT_W-1:0] rd_left_q;

	logic [15:0] mem_q [mhrb_pkg::BANK_WORDS];
	logic [mhrb_pkg::BANK_WORDS-1:0] vld_q;
	logic [15:0] rd_a_s1, rd_b_s1;
	logic        rd_a_vld_s1, rd_b_vld_s1;

	logic           out_valid_q;
	mhrb_pkg::rsp_t out_q;

	logic        in_xfer, out_free, out_load;
	logic [15:0] ev_addr, ev_cnt;
	logic        ev_lo_ok, ev_hi_ok, ev_win_ok;
	logic [mhrb_pkg::IDX_W-1:0] ev_idx;
	logic [1:0]  ev_status;
	logic        ev_rd_go;
	logic        wr_en;
	logic [mhrb_pkg::IDX_W-1:0] wr_idx;
	logic        rd_en;
	logic [mhrb_pkg::IDX_W-1:0] rd_b_idx;
	logic        rd_pair, rd_last;
	logic        eval_go;
	mhrb_pkg::rsp_t out_d;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// window check on the latched request
	assign ev_addr   = item_q.start_address + 16'd1;
	assign ev_cnt    = (item_q.cmd == mhrb_pkg::CMD_WR_SINGLE) ? 16'd1 : item_q.quantity;
	assign ev_lo_ok  = (ev_addr >= first_addr_q);
	assign ev_hi_ok  = (({1'b0, ev_addr} + {1'b0, ev_cnt}) <= win_end_q);
	assign ev_win_ok = ev_lo_ok && ev_hi_ok;
	assign ev_idx    = mhrb_pkg::IDX_W'(ev_addr - first_addr_q);
	assign eval_go   = (state_q == S_EVAL) && out_free;

	always_comb begin
		ev_status = mhrb_pkg::ST_OK;
		ev_rd_go  = 1'b0;
		wr_en     = 1'b0;
		wr_idx    = ev_idx;
		unique case (item_q.cmd)
			mhrb_pkg::CMD_READ: begin
				if (item_q.pdu_length != mhrb_pkg::PDU_LEN_FIXED || item_q.quantity == 16'd0
						|| item_q.quantity > mhrb_pkg::READ_MAX) begin
					ev_status = mhrb_pkg::ST_BAD_VALUE;
				end else if (!ev_win_ok) begin
					ev_status = mhrb_pkg::ST_BAD_ADDR;
				end else begin
					ev_rd_go = 1'b1;
				end
			end
			mhrb_pkg::CMD_WR_SINGLE: begin
				if (item_q.pdu_length != mhrb_pkg::PDU_LEN_FIXED) begin
					ev_status = mhrb_pkg::ST_BAD_VALUE;
				end else if (!ev_win_ok) begin
					ev_status = mhrb_pkg::ST_BAD_ADDR;
				end else begin
					wr_en = eval_go;
				end
			end
			mhrb_pkg::CMD_WR_HEADER: begin
				if (item_q.pdu_length < mhrb_pkg::PDU_LEN_MULTI || item_q.quantity == 16'd0
						|| item_q.quantity > mhrb_pkg::WR_MULTI_MAX
						|| item_q.declared_bytes != {item_q.quantity[6:0], 1'b0}) begin
					ev_status = mhrb_pkg::ST_BAD_VALUE;
				end else if (!ev_win_ok) begin
					ev_status = mhrb_pkg::ST_BAD_ADDR;
				end
			end
			mhrb_pkg::CMD_WR_DATA: begin
				wr_idx = pend_idx_q;
				if (!pend_act_q || pend_rem_q == '0) begin
					ev_status = mhrb_pkg::ST_BAD_VALUE;
				end else begin
					wr_en = eval_go;
				end
			end
			default: begin
				ev_status = mhrb_pkg::ST_BAD_VALUE;
			end
		endcase
	end

	assign rd_en    = (state_q == S_RD_REQ);
	assign rd_pair  = (rd_left_q >= mhrb_pkg::CNT_W'(2));
	assign rd_last  = (rd_left_q <= mhrb_pkg::CNT_W'(2));
	assign rd_b_idx = rd_pair ? (rd_ptr_q + mhrb_pkg::IDX_W'(1)) : rd_ptr_q;

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_d    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) state_d = S_EVAL;
			end
			S_EVAL: begin
				if (out_free) begin
					if (ev_rd_go) begin
						state_d = S_RD_REQ;
					end else begin
						out_load        = 1'b1;
						out_d.status    = ev_status;
						out_d.final_res = 1'b1;
						state_d         = S_IDLE;
					end
				end
			end
			S_RD_REQ: begin
				state_d = S_RD_DATA;
			end
			S_RD_DATA: begin
				if (out_free) begin
					out_load             = 1'b1;
					out_d.status         = mhrb_pkg::ST_OK;
					out_d.first_word     = rd_a_vld_s1 ? rd_a_s1 : 16'd0;
					out_d.second_word    = (rd_pair && rd_b_vld_s1) ? rd_b_s1 : 16'd0;
					out_d.second_present = rd_pair;
					out_d.final_res      = rd_last;
					state_d              = rd_last ? S_IDLE : S_RD_REQ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_addr_q <= mhrb_pkg::FIRST_ADDR_RST;
			win_end_q    <= {1'b0, mhrb_pkg::FIRST_ADDR_RST} + 17'(mhrb_pkg::BANK_WORDS);
			pend_act_q   <= 1'b0;
			pend_idx_q   <= '0;
			pend_rem_q   <= '0;
			vld_q        <= '0;
			rd_a_vld_s1  <= 1'b0;
			rd_b_vld_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (cfg_wr_en) begin
				first_addr_q <= cfg_wr_data;
				win_end_q    <= {1'b0, cfg_wr_data} + 17'(mhrb_pkg::BANK_WORDS);
			end
			if (wr_en) vld_q[wr_idx] <= 1'b1;
			if (rd_en) begin
				rd_a_vld_s1 <= vld_q[rd_ptr_q];
				rd_b_vld_s1 <= vld_q[rd_b_idx];
			end
			if (eval_go) begin
				if (item_q.cmd == mhrb_pkg::CMD_WR_HEADER) begin
					if (ev_status == mhrb_pkg::ST_OK) begin
						pend_act_q <= 1'b1;
						pend_idx_q <= ev_idx;
						pend_rem_q <= mhrb_pkg::CNT_W'(item_q.quantity);
					end else begin
						pend_act_q <= 1'b0;
						pend_idx_q <= '0;
						pend_rem_q <= '0;
					end
				end else if (item_q.cmd == mhrb_pkg::CMD_WR_DATA) begin
					if (ev_status == mhrb_pkg::ST_OK) begin
						pend_idx_q <= pend_idx_q + mhrb_pkg::IDX_W'(1);
						pend_rem_q <= pend_rem_q - mhrb_pkg::CNT_W'(1);
						pend_act_q <= (pend_rem_q != mhrb_pkg::CNT_W'(1));
					end else begin
						pend_act_q <= 1'b0;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) item_q <= in_data;
		if (out_load) out_q <= out_d;
		if (eval_go && ev_rd_go) begin
			rd_ptr_q  <= ev_idx;
			rd_left_q <= mhrb_pkg::CNT_W'(item_q.quantity);
		end else if (state_q == S_RD_DATA && out_free) begin
			rd_ptr_q  <= rd_ptr_q + mhrb_pkg::IDX_W'(2);
			rd_left_q <= rd_left_q - mhrb_pkg::CNT_W'(2);
		end
	end

	// bank memory, one write and two reads a cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_idx] <= item_q.word_value;
		if (rd_en) begin
			rd_a_s1 <= mem_q[rd_ptr_q];
			rd_b_s1 <= mem_q[rd_b_idx];
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_act_q |-> (pend_rem_q != '0))
		else $error("pending write with zero count");

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_act_q |-> (({1'b0, pend_idx_q} + (mhrb_pkg::IDX_W + 1)'(pend_rem_q))
			<= (mhrb_pkg::IDX_W + 1)'(mhrb_pkg::BANK_WORDS)))
		else $error("pending write runs past the bank");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.second_present) |-> (out_data.status == mhrb_pkg::ST_OK))
		else $error("read pair with exception status");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !out_d.final_res) |=> (state_q == S_RD_REQ))
		else $error("read walk stopped before final result");
`endif

endmodule

`default_nettype wire
